FILE: rtl/assert_macros.svh
// assertion macros shared by the filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// expression holds at every clock edge out of reset
`define AST_HOLDS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);
// antecedent in one cycle implies consequent in the next
`define AST_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AST_HOLDS(label, expr, msg)
`define AST_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: rtl/iefilt_pkg.sv
// shared types and constants of the isolated event filter
package iefilt_pkg;

	localparam int MAX_EVENTS_DEF = 64;
	localparam int TIME_BITS_DEF  = 48;
	localparam int QUEUE_DEPTH    = 2;

	localparam int X_W   = 11;
	localparam int Y_W   = 11;
	localparam int R_W   = 8;
	localparam int WIN_W = 24;
	localparam int K_W   = 6;
	localparam int CFG_W = 24;
	localparam int REG_W = 2;

	// register indexes
	localparam logic [REG_W-1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [REG_W-1:0] REG_NEIGHBOR_RADIUS = 2'd1;
	localparam logic [REG_W-1:0] REG_TIME_WINDOW = 2'd2;
	localparam logic [REG_W-1:0] REG_MIN_NEIGHBOR_COUNT = 2'd3;

	// reset values
	localparam logic [R_W-1:0]   RADIUS_RST = 8'd2;
	localparam logic [WIN_W-1:0] WINDOW_RST = 24'd1000;
	localparam logic [K_W-1:0]   MIN_COUNT_RST = 6'd1;

	typedef struct packed {
		logic             enable;
		logic [R_W-1:0]   radius;
		logic [WIN_W-1:0] window;
		logic [K_W-1:0]   min_count;
	} cfg_t;

	// what the back end must do with one queued word
	typedef struct packed {
		logic store;
		logic eval;
		logic ovf;
	} cmd_flags_t;

endpackage

FILE: rtl/iefilt_front.sv
// front end: accepts event words, assigns buffer slots, flags batch ends
`include "assert_macros.svh"
module iefilt_front import iefilt_pkg::*; #(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_EVENTS),
	localparam int CNT_W = $clog2(MAX_EVENTS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [X_W-1:0]       event_x,
	input  logic [Y_W-1:0]       event_y,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic                 batch_end,
	output logic                 push,
	input  logic                 q_full,
	output cmd_flags_t           push_flags,
	output logic [IDX_W-1:0]     push_addr,
	output logic [CNT_W-1:0]     push_n,
	output logic [X_W-1:0]       push_x,
	output logic [Y_W-1:0]       push_y,
	output logic [TIME_BITS-1:0] push_time
);

	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic             has_room;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign has_room = fill_q < CNT_W'(MAX_EVENTS);

	// classify the word: store or drop, evaluate on batch end
	assign push_flags.store = has_room;
	assign push_flags.eval  = batch_end;
	assign push_flags.ovf   = ovf_q || !has_room;
	assign push_addr = fill_q[IDX_W-1:0];
	assign push_n    = has_room ? fill_q + CNT_W'(1) : fill_q;
	assign push_x    = event_x;
	assign push_y    = event_y;
	assign push_time = event_time;

	// fill count and overflow mark of the open batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (push) begin
			if (batch_end) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (has_room) begin
				fill_q <= fill_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	`AST_HOLDS(a_fill_range, fill_q <= CNT_W'(MAX_EVENTS), "fill count beyond capacity")

endmodule

FILE: rtl/iefilt_queue.sv
// short fifo between front end and back end
`include "assert_macros.svh"
module iefilt_queue import iefilt_pkg::*; #(
	parameter int WIDTH = 8,
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full      = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`AST_HOLDS(a_no_push_full, !(push && full), "push into full queue")

endmodule

FILE: rtl/iefilt_back.sv
// back end: event buffer, pairwise neighbor sweep, result output register
`include "assert_macros.svh"
module iefilt_back import iefilt_pkg::*; #(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF,
	localparam int IDX_W = $clog2(MAX_EVENTS),
	localparam int CNT_W = $clog2(MAX_EVENTS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_flags_t           cmd_flags,
	input  logic [IDX_W-1:0]     cmd_addr,
	input  logic [CNT_W-1:0]     cmd_n,
	input  logic [X_W-1:0]       cmd_x,
	input  logic [Y_W-1:0]       cmd_y,
	input  logic [TIME_BITS-1:0] cmd_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [X_W-1:0]       kept_x,
	output logic [Y_W-1:0]       kept_y,
	output logic [TIME_BITS-1:0] kept_time,
	output logic                 run_last,
	output logic                 none_kept,
	output logic                 overflowed
);

	localparam int SQ_W  = 2 * X_W;
	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (CNT_W > K_W) ? CNT_W : K_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SWEEP = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	// event buffer
	logic [X_W-1:0]       mem_x [MAX_EVENTS];
	logic [Y_W-1:0]       mem_y [MAX_EVENTS];
	logic [TIME_BITS-1:0] mem_t [MAX_EVENTS];

	logic [2:0]       state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             keep_q;
	logic             hold_v_q;
	logic [X_W-1:0]       hold_x_q;
	logic [Y_W-1:0]       hold_y_q;
	logic [TIME_BITS-1:0] hold_t_q;
	logic [2*R_W-1:0]     r2_q;

	// compare pipeline
	logic                 v_s1, v_s2, v_s3;
	logic                 self_s1, self_s2, self_s3;
	logic                 last_s1, last_s2, last_s3;
	logic [X_W-1:0]       ax_s1, bx_s1, dx_s2;
	logic [Y_W-1:0]       ay_s1, by_s1, dy_s2;
	logic [TIME_BITS-1:0] at_s1, bt_s1, dt_s2;
	logic [SQ_W-1:0]      dx2_s3, dy2_s3;
	logic                 tok_s3;

	logic             out_valid_q;
	logic [X_W-1:0]       out_x_q;
	logic [Y_W-1:0]       out_y_q;
	logic [TIME_BITS-1:0] out_t_q;
	logic             out_last_q, out_none_q, out_ovf_q;

	logic             last_j, last_i, out_free, hit, keep_now, emit_go, load_out;
	logic [SUM_W-1:0] dist2;
	logic [CNT_W-1:0] final_cnt;
	logic [K_W-1:0]   need;

	assign cmd_ready = state_q == ST_IDLE;
	assign last_j    = (CNT_W'(j_q) + CNT_W'(1)) == n_q;
	assign last_i    = (CNT_W'(i_q) + CNT_W'(1)) == n_q;
	assign out_free  = !out_valid_q || out_ready;

	// neighbor decision at the end of the pipeline
	assign dist2     = {1'b0, dx2_s3} + {1'b0, dy2_s3};
	assign hit       = v_s3 && !self_s3 && tok_s3 && (dist2 <= SUM_W'(r2_q));
	assign final_cnt = cnt_q + CNT_W'(hit);
	assign need      = (cfg.min_count == '0) ? K_W'(1) : cfg.min_count;
	assign keep_now  = !cfg.enable || (CMP_W'(final_cnt) >= CMP_W'(need));

	// a kept row waits only when the held event cannot move to the output yet
	assign emit_go  = !(keep_q && hold_v_q && !out_free);
	assign load_out = (state_q == ST_EMIT && keep_q && hold_v_q && out_free) ||
		(state_q == ST_DONE && out_free);

	// buffer write and two registered read ports
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd_flags.store) begin
			mem_x[cmd_addr] <= cmd_x;
			mem_y[cmd_addr] <= cmd_y;
			mem_t[cmd_addr] <= cmd_time;
		end
		ax_s1 <= mem_x[i_q];
		ay_s1 <= mem_y[i_q];
		at_s1 <= mem_t[i_q];
		bx_s1 <= mem_x[j_q];
		by_s1 <= mem_y[j_q];
		bt_s1 <= mem_t[j_q];
	end

	// distance datapath
	always_ff @(posedge clk) begin
		self_s1 <= j_q == i_q;
		last_s1 <= last_j;
		self_s2 <= self_s1;
		last_s2 <= last_s1;
		dx_s2   <= (ax_s1 >= bx_s1) ? ax_s1 - bx_s1 : bx_s1 - ax_s1;
		dy_s2   <= (ay_s1 >= by_s1) ? ay_s1 - by_s1 : by_s1 - ay_s1;
		dt_s2   <= (at_s1 >= bt_s1) ? at_s1 - bt_s1 : bt_s1 - at_s1;
		self_s3 <= self_s2;
		last_s3 <= last_s2;
		dx2_s3  <= dx_s2 * dx_s2;
		dy2_s3  <= dy_s2 * dy_s2;
		tok_s3  <= dt_s2 <= TIME_BITS'(cfg.window);
		r2_q    <= cfg.radius * cfg.radius;
	end

	// held kept event and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && emit_go && keep_q) begin
			hold_x_q <= ax_s1;
			hold_y_q <= ay_s1;
			hold_t_q <= at_s1;
		end
		if (load_out) begin
			if (state_q == ST_DONE && !hold_v_q) begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_t_q    <= '0;
				out_none_q <= 1'b1;
			end else begin
				out_x_q    <= hold_x_q;
				out_y_q    <= hold_y_q;
				out_t_q    <= hold_t_q;
				out_none_q <= 1'b0;
			end
			out_last_q <= state_q == ST_DONE;
			out_ovf_q  <= ovf_q;
		end
	end

	// sequencer over rows and columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			keep_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= state_q == ST_SWEEP;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (hit && !last_s3) begin
				cnt_q <= final_cnt;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_flags.eval) begin
						n_q      <= cmd_n;
						ovf_q    <= cmd_flags.ovf;
						i_q      <= '0;
						j_q      <= '0;
						cnt_q    <= '0;
						hold_v_q <= 1'b0;
						state_q  <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (last_j) begin
						j_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (v_s3 && last_s3) begin
						keep_q  <= keep_now;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (keep_q) begin
							hold_v_q <= 1'b1;
						end
						if (last_i) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_q + IDX_W'(1);
							cnt_q   <= '0;
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kept_x     = out_x_q;
	assign kept_y     = out_y_q;
	assign kept_time  = out_t_q;
	assign run_last   = out_last_q;
	assign none_kept  = out_none_q;
	assign overflowed = out_ovf_q;

	`AST_HOLDS(a_row_in_range, state_q == ST_IDLE || CNT_W'(i_q) < n_q, "row index past fill")
	`AST_HOLDS(a_pipe_in_sweep, !v_s3 || state_q == ST_SWEEP || state_q == ST_WAIT, "stray compare")
	`AST_NEXT(a_done_loads, state_q == ST_DONE && out_free, out_valid_q, "batch end word lost")

endmodule

FILE: rtl/isolated_event_filter_top.sv
// top level of the isolated event filter
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    event_x, event_y, event_time, batch_end
//   out      source     out_valid / out_ready  kept_x, kept_y, kept_time, run_last,
//                                              none_kept, overflowed
//   cfg      sink       cfg_wen                cfg_addr, cfg_wdata
//
// a word without batch_end leaves the back end idle; the queue buffers words during a sweep
// once the end word reaches the back end, each row is swept one column per cycle through
// the two-port buffer, then the compare pipeline drains and the row is emitted; after the
// last row the final word is loaded into the output register
// the output register holds one result; a stalled output stops the row sequencer
// reset clears control state; buffer and data registers stay undefined, no clearing pass
module isolated_event_filter_top import iefilt_pkg::*; #(
	parameter int MAX_EVENTS = MAX_EVENTS_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [REG_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [X_W-1:0]       event_x,
	input  logic [Y_W-1:0]       event_y,
	input  logic [TIME_BITS-1:0] event_time,
	input  logic                 batch_end,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [X_W-1:0]       kept_x,
	output logic [Y_W-1:0]       kept_y,
	output logic [TIME_BITS-1:0] kept_time,
	output logic                 run_last,
	output logic                 none_kept,
	output logic                 overflowed
);

	localparam int IDX_W = $clog2(MAX_EVENTS);
	localparam int CNT_W = $clog2(MAX_EVENTS + 1);
	localparam int FL_W  = $bits(cmd_flags_t);
	localparam int QW    = FL_W + IDX_W + CNT_W + X_W + Y_W + TIME_BITS;

	cfg_t cfg_q;

	logic                 push, q_full, q_valid, q_pop;
	cmd_flags_t           push_flags, pop_flags;
	logic [IDX_W-1:0]     push_addr, pop_addr;
	logic [CNT_W-1:0]     push_n, pop_n;
	logic [X_W-1:0]       push_x, pop_x;
	logic [Y_W-1:0]       push_y, pop_y;
	logic [TIME_BITS-1:0] push_time, pop_time;
	logic [QW-1:0]        push_word, pop_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable    <= 1'b0;
			cfg_q.radius    <= RADIUS_RST;
			cfg_q.window    <= WINDOW_RST;
			cfg_q.min_count <= MIN_COUNT_RST;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_FILTER_ENABLE:      cfg_q.enable    <= cfg_wdata[0];
				REG_NEIGHBOR_RADIUS:    cfg_q.radius    <= cfg_wdata[R_W-1:0];
				REG_TIME_WINDOW:        cfg_q.window    <= cfg_wdata[WIN_W-1:0];
				REG_MIN_NEIGHBOR_COUNT: cfg_q.min_count <= cfg_wdata[K_W-1:0];
				default: ;
			endcase
		end
	end

	iefilt_front #(
		.MAX_EVENTS(MAX_EVENTS),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.event_x   (event_x),
		.event_y   (event_y),
		.event_time(event_time),
		.batch_end (batch_end),
		.push      (push),
		.q_full    (q_full),
		.push_flags(push_flags),
		.push_addr (push_addr),
		.push_n    (push_n),
		.push_x    (push_x),
		.push_y    (push_y),
		.push_time (push_time)
	);

	// queue word packing
	assign push_word = {push_flags, push_addr, push_n, push_x, push_y, push_time};
	assign {pop_flags, pop_addr, pop_n, pop_x, pop_y, pop_time} = pop_word;

	iefilt_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_word),
		.full     (q_full),
		.pop_valid(q_valid),
		.pop      (q_pop),
		.pop_data (pop_word)
	);

	iefilt_back #(
		.MAX_EVENTS(MAX_EVENTS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd_ready (q_pop),
		.cmd_flags (pop_flags),
		.cmd_addr  (pop_addr),
		.cmd_n     (pop_n),
		.cmd_x     (pop_x),
		.cmd_y     (pop_y),
		.cmd_time  (pop_time),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kept_x    (kept_x),
		.kept_y    (kept_y),
		.kept_time (kept_time),
		.run_last  (run_last),
		.none_kept (none_kept),
		.overflowed(overflowed)
	);

endmodule
